[sv/spa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// shared types and constants of the sorted sparse polynomial accumulator
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_TERMS   = 32;
  localparam int CNT_W       = $clog2(MAX_TERMS + 1);
  localparam int COEF_W      = 32;
  localparam int EXP_W       = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 5;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7fff_ffff;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_READ
  } state_t;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_CMP,
    ACT_INSERT,
    ACT_UPDATE,
    ACT_REMOVE,
    ACT_ROTATE,
    ACT_CLEAR
  } act_t;

  typedef struct packed {
    act_t                     act;
    logic signed [COEF_W-1:0] coef;
    logic signed [EXP_W-1:0]  expo;
  } cmd_t;

  typedef struct packed {
    logic                     valid;
    logic signed [COEF_W-1:0] coef;
    logic signed [EXP_W-1:0]  expo;
  } term_t;

  typedef struct packed {
    logic gt;
    logic match;
    logic zero;
    logic sat;
  } cell_flag_t;

endpackage

[sv/spa_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_cell
// one slot of the sorted term chain: holds a term, compares it with the
// broadcast term and moves terms to and from its neighbors
// ----------------------------------------------------------------------------
module spa_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  spa_pkg::cmd_t       cmd,
  input  spa_pkg::term_t      prev_term,
  input  logic                prev_gt,
  input  spa_pkg::term_t      next_term,
  input  spa_pkg::term_t      head_term,
  output spa_pkg::term_t      term,
  output spa_pkg::cell_flag_t flag
);
  import spa_pkg::*;

  logic                     valid_r, valid_nxt;
  logic signed [COEF_W-1:0] coef_r, coef_nxt;
  logic signed [EXP_W-1:0]  expo_r, expo_nxt;
  logic signed [COEF_W-1:0] sum_r, sum_nxt;
  cell_flag_t               flag_r, flag_nxt;
  logic signed [COEF_W:0]   sum_wide;
  logic                     ovf;

  always_comb begin
    sum_wide = {coef_r[COEF_W-1], coef_r} + {cmd.coef[COEF_W-1], cmd.coef};
    ovf      = sum_wide[COEF_W] != sum_wide[COEF_W-1];
    valid_nxt = valid_r;
    coef_nxt  = coef_r;
    expo_nxt  = expo_r;
    sum_nxt   = sum_r;
    flag_nxt  = flag_r;
    unique case (cmd.act)
      ACT_HOLD: begin
      end
      ACT_CMP: begin
        flag_nxt.gt    = valid_r && ($signed(expo_r) > $signed(cmd.expo));
        flag_nxt.match = valid_r && (expo_r == cmd.expo);
        flag_nxt.zero  = sum_wide == '0;
        flag_nxt.sat   = ovf;
        if (ovf) begin
          sum_nxt = sum_wide[COEF_W] ? COEF_MIN : COEF_MAX;
        end else begin
          sum_nxt = sum_wide[COEF_W-1:0];
        end
      end
      ACT_INSERT: begin
        if (!flag_r.gt && prev_gt) begin
          valid_nxt = 1'b1;
          coef_nxt  = cmd.coef;
          expo_nxt  = cmd.expo;
        end else if (!flag_r.gt) begin
          valid_nxt = prev_term.valid;
          coef_nxt  = prev_term.coef;
          expo_nxt  = prev_term.expo;
        end
      end
      ACT_UPDATE: begin
        if (flag_r.match) begin
          coef_nxt = sum_r;
        end
      end
      ACT_REMOVE: begin
        if (!flag_r.gt) begin
          valid_nxt = next_term.valid;
          coef_nxt  = next_term.coef;
          expo_nxt  = next_term.expo;
        end
      end
      ACT_ROTATE: begin
        if (valid_r && next_term.valid) begin
          coef_nxt = next_term.coef;
          expo_nxt = next_term.expo;
        end else if (valid_r) begin
          coef_nxt = head_term.coef;
          expo_nxt = head_term.expo;
        end
      end
      ACT_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flag_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      flag_r  <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
    expo_r <= expo_nxt;
    sum_r  <= sum_nxt;
  end

  assign term.valid = valid_r;
  assign term.coef  = coef_r;
  assign term.expo  = expo_r;
  assign flag       = flag_r;

endmodule

[sv/spa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_ctrl
// sequencer of the term chain: takes items, issues chain commands, gathers
// the cell flags and drives the result register
// ----------------------------------------------------------------------------
module spa_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [spa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [spa_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [spa_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                            out_tlast,
  output spa_pkg::cmd_t                   cmd,
  input  spa_pkg::term_t                  head_term,
  input  logic [spa_pkg::MAX_TERMS-1:0]   match_v,
  input  logic [spa_pkg::MAX_TERMS-1:0]   zero_v,
  input  logic [spa_pkg::MAX_TERMS-1:0]   sat_v
);
  import spa_pkg::*;

  state_t                   state_r, state_nxt;
  op_t                      op_r, op_nxt;
  logic signed [COEF_W-1:0] val_r, val_nxt;
  logic signed [EXP_W-1:0]  expo_r, expo_nxt;
  logic                     negsat_r, negsat_nxt;
  logic                     zin_r, zin_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic                     ovalid_r, ovalid_nxt;
  logic [OUT_TDATA_W-1:0]   odata_r, odata_nxt;
  logic [OUT_TUSER_W-1:0]   ouser_r, ouser_nxt;
  logic                     olast_r, olast_nxt;

  logic                     in_xfer;
  logic                     slot_free;
  logic signed [COEF_W-1:0] in_coef;
  logic                     in_sub;
  logic                     any_match;
  logic                     any_zero;
  logic                     any_sat;
  logic                     read_last;
  status_t                  st;
  logic                     sat_bit;

  assign in_coef   = in_tdata[COEF_W-1:0];
  assign in_sub    = in_tdata[COEF_W+EXP_W];
  assign in_tready = state_r == S_IDLE;
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !ovalid_r || out_tready;
  assign any_match = |match_v;
  assign any_zero  = |(match_v & zero_v);
  assign any_sat   = |(match_v & sat_v);
  assign read_last = idx_r == (count_r - CNT_W'(1));

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    expo_nxt   = expo_r;
    negsat_nxt = negsat_r;
    zin_nxt    = zin_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    ovalid_nxt = out_tready ? 1'b0 : ovalid_r;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    olast_nxt  = olast_r;
    cmd.act    = ACT_HOLD;
    cmd.coef   = val_r;
    cmd.expo   = expo_r;
    st         = ST_INSERTED;
    sat_bit    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt     = op_t'(in_tuser);
          expo_nxt   = in_tdata[COEF_W+EXP_W-1:COEF_W];
          zin_nxt    = in_coef == '0;
          negsat_nxt = in_sub && (in_coef == COEF_MIN);
          if (in_sub && (in_coef == COEF_MIN)) begin
            val_nxt = COEF_MAX;
          end else if (in_sub) begin
            val_nxt = -in_coef;
          end else begin
            val_nxt = in_coef;
          end
          idx_nxt = '0;
          if ((op_t'(in_tuser) == OP_ADD) && (in_coef != '0)) begin
            state_nxt = S_CMP;
          end else if ((op_t'(in_tuser) == OP_READ) && (count_r != '0)) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_CMP: begin
        cmd.act   = ACT_CMP;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (slot_free) begin
          if (op_r == OP_ADD) begin
            if (zin_r) begin
              st = ST_IGNORED;
            end else if (any_match && any_zero) begin
              st        = ST_REMOVED;
              sat_bit   = negsat_r || any_sat;
              cmd.act   = ACT_REMOVE;
              count_nxt = count_r - CNT_W'(1);
            end else if (any_match) begin
              st      = ST_MERGED;
              sat_bit = negsat_r || any_sat;
              cmd.act = ACT_UPDATE;
            end else if (count_r == CNT_W'(MAX_TERMS)) begin
              st = ST_FULL;
            end else begin
              st        = ST_INSERTED;
              sat_bit   = negsat_r;
              cmd.act   = ACT_INSERT;
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (op_r == OP_CLEAR) begin
            cmd.act   = ACT_CLEAR;
            count_nxt = '0;
          end
          ovalid_nxt = 1'b1;
          odata_nxt  = '0;
          ouser_nxt  = {sat_bit, 1'b0, st};
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_READ: begin
        if (slot_free) begin
          cmd.act    = ACT_ROTATE;
          ovalid_nxt = 1'b1;
          odata_nxt  = {head_term.expo, head_term.coef};
          ouser_nxt  = {1'b0, 1'b1, ST_INSERTED};
          olast_nxt  = read_last;
          idx_nxt    = idx_r + CNT_W'(1);
          if (read_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
      op_r     <= OP_ADD;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
      op_r     <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    expo_r   <= expo_nxt;
    negsat_r <= negsat_nxt;
    zin_r    <= zin_nxt;
    odata_r  <= odata_nxt;
    ouser_r  <= ouser_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule

[sv/sorted_sparse_polynomial_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sparse_polynomial_accumulator
// sparse polynomial kept as a chain of term cells sorted by descending exponent
// ----------------------------------------------------------------------------
// in_* carries commands: in_tuser selects add, readout or clear, in_tdata
// brings the term of an add. out_* carries results, one per add, clear or
// unused opcode, one per stored term for a readout (one empty result when
// nothing is stored), with out_tlast on the final result of each command.
// an add with a nonzero coefficient is compared in every cell and then
// committed, with its result registered at the commit; other single-result
// commands go straight to the commit. a readout gives one result per cycle
// while the result register is free; each result rotates the chain by one
// cell so that the head cell always holds the next term, and after all terms
// the chain is back in order.
// in_tready is high only while the sequencer is idle, so a command is not
// taken before the last result of the previous one is registered.
// while a result is pending and out_tready is low, the result register holds
// and the sequencer waits before its next commit or readout step.
// reset empties the table and drops any pending result; the term values
// themselves are not cleared.
// ----------------------------------------------------------------------------
module sorted_sparse_polynomial_accumulator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // coefficient[31:0], exponent[47:32], subtract[48], zero pad
  input  logic [spa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [spa_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // term_coefficient[31:0], term_exponent[47:32]
  output logic [spa_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[2:0], term_valid[3], saturated[4]
  output logic [spa_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                            out_tlast
);
  import spa_pkg::*;

  cmd_t                 cmd;
  term_t                terms [MAX_TERMS];
  cell_flag_t           flags [MAX_TERMS];
  logic [MAX_TERMS-1:0] match_v;
  logic [MAX_TERMS-1:0] zero_v;
  logic [MAX_TERMS-1:0] sat_v;
  term_t                empty_term;

  assign empty_term = '0;

  genvar i;
  generate
    for (i = 0; i < MAX_TERMS; i++) begin : g_cell
      term_t prev_t;
      term_t next_t;
      logic  prev_g;

      if (i == 0) begin : g_first
        assign prev_t = empty_term;
        assign prev_g = 1'b1;
      end else begin : g_mid
        assign prev_t = terms[i-1];
        assign prev_g = flags[i-1].gt;
      end

      if (i == MAX_TERMS - 1) begin : g_last
        assign next_t = empty_term;
      end else begin : g_body
        assign next_t = terms[i+1];
      end

      spa_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .prev_term (prev_t),
        .prev_gt   (prev_g),
        .next_term (next_t),
        .head_term (terms[0]),
        .term      (terms[i]),
        .flag      (flags[i])
      );

      assign match_v[i] = flags[i].match;
      assign zero_v[i]  = flags[i].zero;
      assign sat_v[i]   = flags[i].sat;
    end
  endgenerate

  spa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .head_term  (terms[0]),
    .match_v    (match_v),
    .zero_v     (zero_v),
    .sat_v      (sat_v)
  );

endmodule

[dv/sorted_sparse_polynomial_accumulator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sparse_polynomial_accumulator_tb
// self-checking bench for the sorted sparse polynomial accumulator
// ----------------------------------------------------------------------------
// commands go in as stream transfers and a term table tracker in the bench
// predicts every result: status of each add, the full term list of each
// readout, saturation of merged sums. a directed opening covers the field
// extremes, the unused opcode, zero terms, saturation, cancellation and empty
// readouts; then the table is filled past capacity and random build, cancel
// and readout sequences follow, mixed with noise commands. both sides stall
// in random bursts except near the end of the run.
// ----------------------------------------------------------------------------
module sorted_sparse_polynomial_accumulator_tb;
  import spa_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         TOTAL_COMMANDS = 180;
  localparam int         STEADY_AFTER   = 150;
  localparam int         STALL_LIMIT    = 2000;
  localparam int         DRAIN_CYCLES   = 20;

  typedef struct {
    status_t     status;
    bit          term_valid;
    logic [31:0] coef;
    logic [15:0] expo;
    bit          last;
    bit          saturated;
  } term_result_t;

  class term_table_tracker;
    logic signed [EXP_W-1:0]  expo_tbl [MAX_TERMS];
    logic signed [COEF_W-1:0] coef_tbl [MAX_TERMS];
    int           term_count;
    term_result_t pending_results [$];
    int           mismatches;
    int           results_checked;
    int           status_count [5];
    int           saturations;
    int           readouts;
    int           longest_readout;

    function void push_result(status_t st, bit tv, logic [31:0] c, logic [15:0] e,
                              bit last, bit sat);
      term_result_t r;
      r.status     = st;
      r.term_valid = tv;
      r.coef       = c;
      r.expo       = e;
      r.last       = last;
      r.saturated  = sat;
      pending_results.push_back(r);
    endfunction

    function longint clamp_coef(input longint v, inout bit sat);
      if (v > longint'(COEF_MAX)) begin
        sat = 1'b1;
        return longint'(COEF_MAX);
      end
      if (v < longint'(COEF_MIN)) begin
        sat = 1'b1;
        return longint'(COEF_MIN);
      end
      return v;
    endfunction

    function status_t merge_term(logic signed [COEF_W-1:0] c, logic signed [EXP_W-1:0] e,
                                 bit sub, output bit sat);
      longint val;
      longint sum;
      int     pos;
      int     i;
      sat = 1'b0;
      if (c == 0) return ST_IGNORED;
      val = sub ? -longint'(c) : longint'(c);
      val = clamp_coef(val, sat);
      for (i = 0; i < term_count; i++) begin
        if (expo_tbl[i] == e) begin
          sum = clamp_coef(longint'(coef_tbl[i]) + val, sat);
          if (sum == 0) begin
            for (pos = i; pos + 1 < term_count; pos++) begin
              expo_tbl[pos] = expo_tbl[pos + 1];
              coef_tbl[pos] = coef_tbl[pos + 1];
            end
            term_count--;
            return ST_REMOVED;
          end
          coef_tbl[i] = sum[31:0];
          return ST_MERGED;
        end
      end
      if (term_count >= MAX_TERMS) begin
        sat = 1'b0;
        return ST_FULL;
      end
      pos = term_count;
      for (i = 0; i < term_count; i++) begin
        if (expo_tbl[i] < e) begin
          pos = i;
          break;
        end
      end
      for (i = term_count; i > pos; i--) begin
        expo_tbl[i] = expo_tbl[i - 1];
        coef_tbl[i] = coef_tbl[i - 1];
      end
      expo_tbl[pos] = e;
      coef_tbl[pos] = val[31:0];
      term_count++;
      return ST_INSERTED;
    endfunction

    function void note_command(logic [1:0] op, logic signed [COEF_W-1:0] c,
                               logic signed [EXP_W-1:0] e, bit sub);
      status_t st;
      bit      sat;
      int      i;
      case (op)
        OP_ADD: begin
          st = merge_term(c, e, sub, sat);
          status_count[st]++;
          if (sat) saturations++;
          push_result(st, 1'b0, '0, '0, 1'b1, sat);
        end
        OP_READ: begin
          readouts++;
          if (term_count > longest_readout) longest_readout = term_count;
          if (term_count == 0) begin
            push_result(ST_INSERTED, 1'b0, '0, '0, 1'b1, 1'b0);
          end else begin
            for (i = 0; i < term_count; i++)
              push_result(ST_INSERTED, 1'b1, coef_tbl[i], expo_tbl[i],
                          i == term_count - 1, 1'b0);
          end
        end
        OP_CLEAR: begin
          term_count = 0;
          push_result(ST_INSERTED, 1'b0, '0, '0, 1'b1, 1'b0);
        end
        default: begin
          push_result(ST_INSERTED, 1'b0, '0, '0, 1'b1, 1'b0);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser,
                               logic tlast);
      term_result_t r;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: tdata %0h tuser %0h tlast %0b",
               tdata, tuser, tlast);
        mismatches++;
        return;
      end
      r = pending_results.pop_front();
      results_checked++;
      compare_field("status", 32'(r.status), 32'(tuser[2:0]));
      compare_field("term_valid", 32'(r.term_valid), 32'(tuser[3]));
      compare_field("saturated", 32'(r.saturated), 32'(tuser[4]));
      compare_field("term_coefficient", r.coef, tdata[31:0]);
      compare_field("term_exponent", 32'(r.expo), 32'(tdata[47:32]));
      compare_field("last", 32'(r.last), 32'(tlast));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  term_table_tracker poly;
  int                commands_sent;
  bit                steady;
  int                stall_cycles = 0;

  sorted_sparse_polynomial_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_command(logic [1:0] op, logic signed [COEF_W-1:0] c,
                              logic signed [EXP_W-1:0] e, bit sub);
    int gap;
    if (!steady && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, sub, e, c};
    do @(posedge clk); while (!in_tready);
    poly.note_command(op, c, e, sub);
    commands_sent++;
    if (commands_sent >= STEADY_AFTER) steady = 1'b1;
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (poly.pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      poly.check_result(out_tdata, out_tuser, out_tlast);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 99) < 35) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    logic signed [EXP_W-1:0]  expo_pool [6];
    logic signed [COEF_W-1:0] c;
    logic signed [EXP_W-1:0]  e;
    int                       idx;
    int                       n;
    int                       pick;
    int                       k;

    poly          = new();
    commands_sent = 0;
    steady        = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening
    send_command(OP_READ, 32'sd0, 16'sd0, 1'b0);
    send_command(OP_CLEAR, 32'sd0, 16'sd0, 1'b0);
    send_command(OP_UNUSED, 32'($urandom), 16'($urandom), 1'b1);
    send_command(OP_ADD, 32'sd0, 16'($urandom), 1'b1);
    send_command(OP_ADD, COEF_MAX, 16'sh7fff, 1'b0);
    send_command(OP_ADD, COEF_MIN, 16'sh8000, 1'b0);
    send_command(OP_ADD, 32'sd5, 16'sd0, 1'b1);
    send_command(OP_ADD, 32'sd1, 16'sh7fff, 1'b0);
    send_command(OP_ADD, 32'sd1, 16'sh8000, 1'b1);
    send_command(OP_ADD, COEF_MIN, 16'sd0, 1'b1);
    send_command(OP_ADD, COEF_MAX - 32'sd5, 16'sd0, 1'b1);
    send_command(OP_ADD, COEF_MIN, 16'sd100, 1'b1);
    send_command(OP_ADD, -32'sd1, -16'sd1, 1'b0);
    send_command(OP_READ, 32'sd0, 16'sd0, 1'b0);
    send_command(OP_ADD, COEF_MAX, 16'sh7fff, 1'b1);
    send_command(OP_ADD, 32'sd0, 16'sh7fff, 1'b0);
    send_command(OP_UNUSED, 32'hffff_ffff, 16'hffff, 1'b1);
    send_command(OP_READ, 32'sd0, 16'sd0, 1'b0);
    send_command(OP_CLEAR, 32'sd0, 16'sd0, 1'b0);
    send_command(OP_READ, 32'sd0, 16'sd0, 1'b0);
    wait_drained();

    // fill the table past capacity, touch it while full, then read it all
    send_command(OP_CLEAR, 32'($urandom), 16'($urandom), 1'($urandom));
    while (poly.term_count < MAX_TERMS) begin
      c = 32'($urandom);
      if (c == 0) c = 32'sd1;
      send_command(OP_ADD, c, 16'($urandom), 1'($urandom));
    end
    for (k = 0; k < 3; k++) begin
      send_command(OP_ADD, 32'($urandom) | 32'sd1, 16'($urandom), 1'($urandom));
    end
    idx = $urandom_range(0, poly.term_count - 1);
    send_command(OP_ADD, 32'sd3, poly.expo_tbl[idx], 1'b0);
    send_command(OP_READ, 32'sd0, 16'sd0, 1'b0);
    idx = $urandom_range(0, poly.term_count - 1);
    send_command(OP_ADD, poly.coef_tbl[idx], poly.expo_tbl[idx], 1'b1);
    send_command(OP_ADD, 32'sd7, 16'($urandom), 1'b0);
    send_command(OP_READ, 32'sd0, 16'sd0, 1'b0);

    while (commands_sent < TOTAL_COMMANDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed: build on a small exponent pool, then usually read back
        for (k = 0; k < 6; k++) expo_pool[k] = 16'($urandom);
        if ($urandom_range(0, 1)) send_command(OP_CLEAR, 32'sd0, 16'sd0, 1'b0);
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 25 && poly.term_count > 0) begin
            idx = $urandom_range(0, poly.term_count - 1);
            send_command(OP_ADD, poly.coef_tbl[idx], poly.expo_tbl[idx], 1'b1);
          end else if (pick < 35) begin
            case ($urandom_range(0, 3))
              0: c = COEF_MAX;
              1: c = COEF_MIN;
              2: c = 32'sd1;
              default: c = -32'sd1;
            endcase
            send_command(OP_ADD, c, expo_pool[$urandom_range(0, 5)], 1'($urandom));
          end else if (pick < 40) begin
            send_command(OP_ADD, 32'sd0, expo_pool[$urandom_range(0, 5)], 1'($urandom));
          end else begin
            send_command(OP_ADD, 32'($urandom), expo_pool[$urandom_range(0, 5)],
                         1'($urandom));
          end
        end
        if ($urandom_range(0, 99) < 80)
          send_command(OP_READ, 32'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        // noise: any opcode with any payload
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          e = 16'($urandom);
          send_command(2'($urandom), 32'($urandom), e, 1'($urandom));
        end
      end
    end

    in_tvalid <= 1'b0;
    while (poly.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands, %0d results; adds inserted %0d, merged %0d, removed %0d",
             commands_sent, poly.results_checked, poly.status_count[ST_INSERTED],
             poly.status_count[ST_MERGED], poly.status_count[ST_REMOVED]);
    $display("zero terms %0d, table full %0d, saturated %0d, readouts %0d (longest %0d)",
             poly.status_count[ST_IGNORED], poly.status_count[ST_FULL], poly.saturations,
             poly.readouts, poly.longest_readout);
    if (poly.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
